[rtl/ang_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ang_pkg
// Shared types, register map and constants of the audio noise gate.
// ----------------------------------------------------------------------------
package ang_pkg;

	// Fixed-point reference points
	localparam int unsigned ONE_Q24 = 16777216;
	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

	// Default build constants
	localparam int unsigned FLOOR_GAIN_DEF   = 16777;
	localparam int unsigned ATTACK_COEFF_DEF = 349525;

	// Gate mode codes
	localparam logic [1:0] MODE_CLOSED  = 2'd0;
	localparam logic [1:0] MODE_OPEN    = 2'd1;
	localparam logic [1:0] MODE_CLOSING = 2'd2;

	// Register map (index = byte address / 4)
	localparam int unsigned ADDR_W = 5;
	localparam logic [2:0] REG_ENABLE     = 3'd0;
	localparam logic [2:0] REG_OPEN_LVL   = 3'd1;
	localparam logic [2:0] REG_RETRIG_LVL = 3'd2;
	localparam logic [2:0] REG_CLOSE_LVL  = 3'd3;
	localparam logic [2:0] REG_DET_DECAY  = 3'd4;
	localparam logic [2:0] REG_REL_COEFF  = 3'd5;
	localparam logic [2:0] REG_HOLD       = 3'd6;
	localparam logic [2:0] REG_CONFIRM    = 3'd7;

	// Register reset values
	localparam logic        RST_ENABLE     = 1'b1;
	localparam logic [24:0] RST_OPEN_LVL   = 25'd167772;
	localparam logic [24:0] RST_RETRIG_LVL = 25'd335544;
	localparam logic [24:0] RST_CLOSE_LVL  = 25'd83886;
	localparam logic [24:0] RST_DET_DECAY  = 25'd16609443;
	localparam logic [24:0] RST_REL_COEFF  = 25'd3355;
	localparam logic [15:0] RST_HOLD       = 16'd2400;
	localparam logic [15:0] RST_CONFIRM    = 16'd12000;

	typedef struct packed {
		logic        enable;
		logic [24:0] open_level;
		logic [24:0] retrigger_level;
		logic [24:0] close_level;
		logic [24:0] detector_decay;
		logic [24:0] release_coeff;
		logic [15:0] hold_samples;
		logic [15:0] confirm_samples;
	} cfg_t;

	// Shared multiplier operand selection
	typedef enum logic [1:0] {
		MUL_ENV   = 2'd0,
		MUL_GAIN1 = 2'd1,
		MUL_GAIN2 = 2'd2,
		MUL_OUT   = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     env_take_m;
		logic     env_upd;
		logic     gate_upd;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     g1_upd;
		logic     g2_upd;
		logic     out_load;
		logic     out_pass;
	} cmd_t;

	typedef struct packed {
		logic env_gt;
		logic mode_open;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

[rtl/ang_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ang_regs
// APB configuration register file of the noise gate.
// ----------------------------------------------------------------------------
module ang_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ang_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output ang_pkg::cfg_t                   cfg
);
	import ang_pkg::*;

	logic [2:0] idx;
	logic       wr;
	cfg_t       cfg_q;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= RST_ENABLE;
			cfg_q.open_level      <= RST_OPEN_LVL;
			cfg_q.retrigger_level <= RST_RETRIG_LVL;
			cfg_q.close_level     <= RST_CLOSE_LVL;
			cfg_q.detector_decay  <= RST_DET_DECAY;
			cfg_q.release_coeff   <= RST_REL_COEFF;
			cfg_q.hold_samples    <= RST_HOLD;
			cfg_q.confirm_samples <= RST_CONFIRM;
		end else if (wr) begin
			case (idx)
				REG_ENABLE:     cfg_q.enable          <= pwdata[0];
				REG_OPEN_LVL:   cfg_q.open_level      <= pwdata[24:0];
				REG_RETRIG_LVL: cfg_q.retrigger_level <= pwdata[24:0];
				REG_CLOSE_LVL:  cfg_q.close_level     <= pwdata[24:0];
				REG_DET_DECAY:  cfg_q.detector_decay  <= pwdata[24:0];
				REG_REL_COEFF:  cfg_q.release_coeff   <= pwdata[24:0];
				REG_HOLD:       cfg_q.hold_samples    <= pwdata[15:0];
				REG_CONFIRM:    cfg_q.confirm_samples <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ENABLE:     prdata = {31'd0, cfg_q.enable};
			REG_OPEN_LVL:   prdata = {7'd0, cfg_q.open_level};
			REG_RETRIG_LVL: prdata = {7'd0, cfg_q.retrigger_level};
			REG_CLOSE_LVL:  prdata = {7'd0, cfg_q.close_level};
			REG_DET_DECAY:  prdata = {7'd0, cfg_q.detector_decay};
			REG_REL_COEFF:  prdata = {7'd0, cfg_q.release_coeff};
			REG_HOLD:       prdata = {16'd0, cfg_q.hold_samples};
			REG_CONFIRM:    prdata = {16'd0, cfg_q.confirm_samples};
			default:        prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

[rtl/ang_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ang_ctrl
// Sequencer of the noise gate: steps one sample through the shared datapath.
// ----------------------------------------------------------------------------
module ang_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic           enable,
	input  wire ang_pkg::stat_t stat,
	output ang_pkg::cmd_t       cmd
);
	import ang_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PASS,
		ST_ENV,
		ST_ENV_UPD,
		ST_GATE,
		ST_G1_MUL,
		ST_G1_UPD,
		ST_G2_MUL,
		ST_G2_UPD,
		ST_OUT_MUL,
		ST_OUT_UPD
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.mul_sel = MUL_ENV;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = enable ? ST_ENV : ST_PASS;
				end
			end
			ST_PASS: begin
				if (stat.out_free) begin
					cmd.out_pass = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			ST_ENV: begin
				if (stat.env_gt) begin
					cmd.env_take_m = 1'b1;
					state_nxt      = ST_GATE;
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_ENV;
					state_nxt   = ST_ENV_UPD;
				end
			end
			ST_ENV_UPD: begin
				cmd.env_upd = 1'b1;
				state_nxt   = ST_GATE;
			end
			ST_GATE: begin
				cmd.gate_upd = 1'b1;
				state_nxt    = ST_G1_MUL;
			end
			ST_G1_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GAIN1;
				state_nxt   = ST_G1_UPD;
			end
			ST_G1_UPD: begin
				cmd.g1_upd = 1'b1;
				state_nxt  = stat.mode_open ? ST_OUT_MUL : ST_G2_MUL;
			end
			ST_G2_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GAIN2;
				state_nxt   = ST_G2_UPD;
			end
			ST_G2_UPD: begin
				cmd.g2_upd = 1'b1;
				state_nxt  = ST_OUT_MUL;
			end
			ST_OUT_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_OUT;
				state_nxt   = ST_OUT_UPD;
			end
			ST_OUT_UPD: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Capture only from idle
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (state_q == ST_IDLE))
		else $error("capture outside idle");

	// An accepted sample always starts work in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted sample did not start");

	// No two of the multiply, envelope, gate and gain update commands are issued together
	a_one_mul: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul_en, cmd.g1_upd, cmd.g2_upd, cmd.gate_upd, cmd.env_upd}))
		else $error("overlapping datapath commands");

endmodule
`default_nettype wire

[rtl/ang_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ang_dp
// Datapath of the noise gate: envelope, gate mode, gain state, one shared
// multiplier and the result register.
// ----------------------------------------------------------------------------
module ang_dp #(
	parameter int unsigned FLOOR_GAIN   = ang_pkg::FLOOR_GAIN_DEF,
	parameter int unsigned ATTACK_COEFF = ang_pkg::ATTACK_COEFF_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ang_pkg::cmd_t  cmd,
	output ang_pkg::stat_t      stat,
	input  wire ang_pkg::cfg_t  cfg,
	input  wire logic [23:0]    sample_in,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [23:0]         sample_out,
	output logic [1:0]          gate_state
);
	import ang_pkg::*;

	localparam int unsigned FLOOR_SAT = (FLOOR_GAIN > ONE_Q24) ? ONE_Q24 : FLOOR_GAIN;
	localparam logic [31:0] FLOOR_Q31 = 32'(FLOOR_SAT) << 7;
	localparam logic [24:0] ATTACK_SAT =
		25'((ATTACK_COEFF > ONE_Q24) ? ONE_Q24 : ATTACK_COEFF);
	localparam logic [24:0] COEF_ONE = 25'(ONE_Q24);

	function automatic logic [31:0] clamp_gain(input logic [32:0] g);
		logic [31:0] r;
		if (g > {1'b0, ONE_Q31})
			r = ONE_Q31;
		else if (g < {1'b0, FLOOR_Q31})
			r = FLOOR_Q31;
		else
			r = g[31:0];
		return r;
	endfunction

	logic [23:0] sample_q;
	logic [23:0] env_q;
	logic [31:0] gain_q;
	logic [31:0] rs_q;
	logic [15:0] hold_q;
	logic [15:0] conf_q;
	logic [1:0]  mode_q;
	logic [56:0] p_q;
	logic        up_q;
	logic        out_valid_q;
	logic [23:0] sample_out_q;
	logic [1:0]  gate_state_q;

	logic        neg;
	logic [23:0] mag;
	logic [23:0] m;
	logic [24:0] decay_sat;
	logic [24:0] rc_sat;
	logic        is_open;
	logic        out_free;

	assign neg       = sample_q[23];
	assign mag       = neg ? (24'd0 - sample_q) : sample_q;
	assign m         = mag[23] ? 24'hFF_FFFF : {mag[22:0], 1'b0};
	assign decay_sat = (cfg.detector_decay > COEF_ONE) ? COEF_ONE : cfg.detector_decay;
	assign rc_sat    = (cfg.release_coeff > COEF_ONE) ? COEF_ONE : cfg.release_coeff;
	assign is_open   = (mode_q == MODE_OPEN);
	assign out_free  = !out_valid_q || !out_stall;

	assign stat.env_gt    = (m > env_q);
	assign stat.mode_open = is_open;
	assign stat.out_free  = out_free;

	// Shared multiplier operands
	logic [31:0] tgt;
	logic [31:0] val;
	logic        up;
	logic [31:0] diff;
	logic [31:0] mul_a;
	logic [24:0] mul_b;

	always_comb begin
		tgt = rs_q;
		val = gain_q;
		if (cmd.mul_sel == MUL_GAIN1) begin
			tgt = is_open ? ONE_Q31 : FLOOR_Q31;
			val = is_open ? gain_q : rs_q;
		end
		up   = (tgt >= val);
		diff = up ? (tgt - val) : (val - tgt);
		case (cmd.mul_sel)
			MUL_ENV: begin
				mul_a = {8'd0, env_q};
				mul_b = decay_sat;
			end
			MUL_GAIN1: begin
				mul_a = diff;
				mul_b = is_open ? ATTACK_SAT : rc_sat;
			end
			MUL_GAIN2: begin
				mul_a = diff;
				mul_b = rc_sat;
			end
			MUL_OUT: begin
				mul_a = gain_q;
				mul_b = {1'b0, mag};
			end
			default: begin
				mul_a = {8'd0, env_q};
				mul_b = decay_sat;
			end
		endcase
	end

	// Step toward the target by the registered delta
	logic [31:0] delta;
	logic [31:0] step_val;
	logic [32:0] stepped;
	logic [31:0] step_clamped;

	assign delta        = p_q[55:24];
	assign step_val     = (cmd.g2_upd || is_open) ? gain_q : rs_q;
	assign stepped      = up_q ? ({1'b0, step_val} + {1'b0, delta})
	                           : ({1'b0, step_val} - {1'b0, delta});
	assign step_clamped = clamp_gain(stepped);

	// Gate mode next values
	logic [24:0] env_ext;
	logic [1:0]  mode_nxt;
	logic [15:0] hold_nxt;
	logic [15:0] conf_nxt;

	assign env_ext = {1'b0, env_q};

	always_comb begin
		mode_nxt = mode_q;
		hold_nxt = hold_q;
		conf_nxt = conf_q;
		case (mode_q)
			MODE_OPEN: begin
				if (env_ext > cfg.open_level) begin
					hold_nxt = cfg.hold_samples;
				end else if (env_ext < cfg.close_level) begin
					if (hold_q != 16'd0) begin
						hold_nxt = hold_q - 16'd1;
					end else begin
						mode_nxt = MODE_CLOSING;
						conf_nxt = cfg.confirm_samples;
					end
				end
			end
			MODE_CLOSING: begin
				if (env_ext > cfg.retrigger_level) begin
					mode_nxt = MODE_OPEN;
					hold_nxt = cfg.hold_samples;
				end else if (env_ext > cfg.close_level) begin
					conf_nxt = cfg.confirm_samples;
				end else if (conf_q != 16'd0) begin
					conf_nxt = conf_q - 16'd1;
				end else begin
					mode_nxt = MODE_CLOSED;
				end
			end
			default: begin
				mode_nxt = MODE_CLOSED;
				if (env_ext > cfg.open_level) begin
					mode_nxt = MODE_OPEN;
					hold_nxt = cfg.hold_samples;
				end
			end
		endcase
	end

	// Result magnitude and signed result
	logic [23:0] prod;
	assign prod = p_q[54:31];

	always_ff @(posedge clk) begin
		if (cmd.capture)
			sample_q <= sample_in;
		if (cmd.mul_en) begin
			p_q  <= {25'd0, mul_a} * {32'd0, mul_b};
			up_q <= up;
		end
		if (cmd.out_load) begin
			sample_out_q <= neg ? (24'd0 - prod) : prod;
			gate_state_q <= mode_q;
		end else if (cmd.out_pass) begin
			sample_out_q <= sample_q;
			gate_state_q <= mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q       <= '0;
			gain_q      <= FLOOR_Q31;
			rs_q        <= FLOOR_Q31;
			hold_q      <= '0;
			conf_q      <= '0;
			mode_q      <= MODE_CLOSED;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.env_take_m)
				env_q <= m;
			else if (cmd.env_upd)
				env_q <= p_q[47:24];
			if (cmd.gate_upd) begin
				mode_q <= mode_nxt;
				hold_q <= hold_nxt;
				conf_q <= conf_nxt;
			end
			if (cmd.g1_upd) begin
				if (is_open) begin
					gain_q <= step_clamped;
					rs_q   <= step_clamped;
				end else begin
					rs_q <= stepped[31:0];
				end
			end
			if (cmd.g2_upd) begin
				gain_q <= step_clamped;
				rs_q   <= clamp_gain({1'b0, rs_q});
			end
			if (cmd.out_load || cmd.out_pass)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign gate_state = gate_state_q;

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(gain_q <= ONE_Q31) && (gain_q >= FLOOR_Q31))
		else $error("gain out of range");

	a_rs_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> ((rs_q <= ONE_Q31) && (rs_q >= FLOOR_Q31)))
		else $error("release stage out of range");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_CLOSED) || (mode_q == MODE_OPEN) || (mode_q == MODE_CLOSING))
		else $error("bad gate mode");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load || cmd.out_pass) |-> (!out_valid_q || !out_stall))
		else $error("result overwritten before taken");

endmodule
`default_nettype wire

[rtl/audio_noise_gate_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// audio_noise_gate_top
// Noise gate with peak detector, hysteresis, hold and close confirmation.
// ----------------------------------------------------------------------------
// Sequence: an enabled sample walks the envelope, gate, gain and output
//   steps (no envelope multiply on attack, no second release step while open);
//   a disabled one passes straight out. A result still stalled downstream
//   adds its wait, since the next result cannot load before it. The single
//   shared multiplier forms the envelope, gain and output products in turn;
//   a new sample is accepted only after the last one has loaded its result.
// Reset: arst_n clears envelope, counts and mode (closed), sets gain state to
//   the floor and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module audio_noise_gate_top #(
	parameter int unsigned FLOOR_GAIN   = ang_pkg::FLOOR_GAIN_DEF,
	parameter int unsigned ATTACK_COEFF = ang_pkg::ATTACK_COEFF_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input sample channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [23:0]                sample_in,
	// result channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [23:0]                     sample_out,
	output logic [1:0]                      gate_state,
	// configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ang_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready
);
	import ang_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	// Register file: all fields but enable are read by the datapath, enable by the sequencer
	ang_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: accept a transaction only when idle, then walk envelope ->
	// gate -> gain -> output branching on datapath status, or pass when disabled.
	ang_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.enable   (cfg.enable),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: holds all gate state and the result register, so the next
	// transaction may be accepted while a result still waits downstream.
	ang_dp #(
		.FLOOR_GAIN   (FLOOR_GAIN),
		.ATTACK_COEFF (ATTACK_COEFF)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg        (cfg),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.gate_state (gate_state)
	);

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the audio noise gate: a directed table of samples
// and register writes, then phases of random bursts under random and extreme
// register settings, results checked against typed rows or a cycle-free model.
// ----------------------------------------------------------------------------
module testbench;
	import ang_pkg::*;

	// Run shape
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 12;    // worst result latency plus margin
	localparam int NUM_PHASES   = 10;
	localparam int PHASE_ITEMS  = 70;
	localparam int MAX_PRINTS   = 40;

	// Floor gain in Q1.31, as the block builds it by default
	localparam logic [31:0] FLOOR_Q31 = 32'(FLOOR_GAIN_DEF) << 7;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
	typedef enum logic [1:0] {BURST_LOUD, BURST_QUIET, BURST_SILENT, BURST_NOISE} burst_t;

	typedef struct packed {
		logic [23:0] sample;
		logic [1:0]  state;
	} gate_out_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;        // register index of a write row
		logic [31:0] value;      // sample (low 24 bits) or register data
		logic        typed;      // expected result given in the row
		logic [23:0] want_out;
		logic [1:0]  want_state;
	} dir_row_t;

	localparam int DIR_ROWS = 23;

	// Directed table: silence and tiny samples after reset, full-scale extremes,
	// then short hold/confirm with instant decay to walk open, closing, the
	// confirm reload, a retrigger and the return to closed, then pass-through.
	dir_row_t dir_tbl [0:DIR_ROWS-1] = '{
		'{ROW_SAMPLE, REG_ENABLE,    32'h0000000, 1'b1, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0000001, 1'b1, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0FFFFFF, 1'b1, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h07FFFFF, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0800000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0400000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_WRITE,  REG_HOLD,      32'h0000001, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_WRITE,  REG_CONFIRM,   32'h0000001, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_WRITE,  REG_DET_DECAY, 32'h0000000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_WRITE,  REG_REL_COEFF, 32'h1FFFFFF, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h07FFFFF, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0000000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0000000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0020000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h07FFFFF, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0000000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0000000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0000000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0000000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_WRITE,  REG_ENABLE,    32'h0000000, 1'b0, 24'h000000, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h07FFFFF, 1'b1, 24'h7FFFFF, MODE_CLOSED},
		'{ROW_SAMPLE, REG_ENABLE,    32'h0800000, 1'b1, 24'h800000, MODE_CLOSED},
		'{ROW_WRITE,  REG_ENABLE,    32'h0000001, 1'b0, 24'h000000, MODE_CLOSED}
	};

	// Block ports; every input starts at a known value
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [23:0] sample_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [23:0] sample_out;
	logic [1:0]  gate_state;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Gate model state and its copy of the registers
	cfg_t        cfg_shadow;
	logic [23:0] env_lvl;
	logic [31:0] gain_q31;
	logic [31:0] rel_q31;
	logic [15:0] hold_cnt;
	logic [15:0] confirm_cnt;
	logic [1:0]  gate_mode;

	gate_out_t   gated_q[$];    // gated samples still owed by the block
	int          errors = 0;
	int          cycle_cnt = 0;
	bit          idle_en = 1'b1; // both sides draw random gaps when set

	audio_noise_gate_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.gate_state (gate_state),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	// Coefficients above one act as exactly one
	function automatic logic [24:0] unit_sat(input logic [24:0] c);
		return (c > 25'(ONE_Q24)) ? 25'(ONE_Q24) : c;
	endfunction

	// Move cur toward goal by (goal - cur) * c, the step truncated toward zero
	function automatic logic [31:0] glide_q31(input logic [31:0] cur, input logic [31:0] goal,
			input logic [24:0] c);
		logic [63:0] step;
		if (goal >= cur) begin
			step = (64'(goal - cur) * 64'(c)) >> 24;
			return cur + step[31:0];
		end
		step = (64'(cur - goal) * 64'(c)) >> 24;
		return cur - step[31:0];
	endfunction

	function automatic logic [31:0] clamp_q31(input logic [31:0] g);
		if (g > ONE_Q31)
			return ONE_Q31;
		if (g < FLOOR_Q31)
			return FLOOR_Q31;
		return g;
	endfunction

	// Advance the gate model by one sample and return the gated result
	function automatic gate_out_t gate_sample(input logic [23:0] smp);
		gate_out_t   res;
		logic        neg;
		logic [23:0] mag;
		logic [23:0] peak;
		logic [63:0] prod;
		neg = smp[23];
		mag = neg ? 24'(0) - smp : smp;
		if (!cfg_shadow.enable) begin
			res.sample = smp;
			res.state  = gate_mode;
			return res;
		end
		// peak detector: instant attack, multiplicative release
		peak = (mag > 24'h7FFFFF) ? 24'hFFFFFF : {mag[22:0], 1'b0};
		if (peak > env_lvl)
			env_lvl = peak;
		else begin
			prod = 64'(env_lvl) * 64'(unit_sat(cfg_shadow.detector_decay));
			env_lvl = prod[47:24];
		end
		case (gate_mode)
			MODE_OPEN: begin
				if (env_lvl > cfg_shadow.open_level)
					hold_cnt = cfg_shadow.hold_samples;
				else if (env_lvl < cfg_shadow.close_level) begin
					if (hold_cnt != 0)
						hold_cnt--;
					else begin
						gate_mode   = MODE_CLOSING;
						confirm_cnt = cfg_shadow.confirm_samples;
					end
				end
			end
			MODE_CLOSING: begin
				if (env_lvl > cfg_shadow.retrigger_level) begin
					gate_mode = MODE_OPEN;
					hold_cnt  = cfg_shadow.hold_samples;
				end else if (env_lvl > cfg_shadow.close_level)
					confirm_cnt = cfg_shadow.confirm_samples;
				else if (confirm_cnt != 0)
					confirm_cnt--;
				else
					gate_mode = MODE_CLOSED;
			end
			default: begin
				gate_mode = MODE_CLOSED;
				if (env_lvl > cfg_shadow.open_level) begin
					gate_mode = MODE_OPEN;
					hold_cnt  = cfg_shadow.hold_samples;
				end
			end
		endcase
		// gain smoothing: ramp up while open, two-stage release otherwise
		if (gate_mode == MODE_OPEN) begin
			gain_q31 = glide_q31(gain_q31, ONE_Q31, unit_sat(25'(ATTACK_COEFF_DEF)));
			rel_q31  = gain_q31;
		end else begin
			rel_q31  = glide_q31(rel_q31, FLOOR_Q31, unit_sat(cfg_shadow.release_coeff));
			gain_q31 = glide_q31(gain_q31, rel_q31, unit_sat(cfg_shadow.release_coeff));
		end
		gain_q31 = clamp_q31(gain_q31);
		rel_q31  = clamp_q31(rel_q31);
		prod = (64'(mag) * 64'(gain_q31)) >> 31;
		res.sample = neg ? 24'(0) - prod[23:0] : prod[23:0];
		res.state  = gate_mode;
		return res;
	endfunction

	// Present one sample after a random gap; book its result once the
	// transaction completes. Valid stays up on return so back-to-back
	// samples never see a low pulse.
	task automatic send_sample(input logic [23:0] smp, input logic typed, input gate_out_t want);
		int        gap;
		gate_out_t res;
		gap = idle_en ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= smp;
		do @(posedge clk); while (in_stall);
		res = gate_sample(smp);
		if (typed)
			res = want;
		gated_q.push_back(res);
	endtask

	// Wait for every owed result, then let the pipeline go quiet
	task automatic settle();
		while (gated_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register (junk above its width), mirror it, read it back
	task automatic access_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] keep;
		logic [31:0] wdata;
		case (idx)
			REG_ENABLE:            keep = 32'h0000_0001;
			REG_HOLD, REG_CONFIRM: keep = 32'h0000_FFFF;
			default:               keep = 32'h01FF_FFFF;
		endcase
		wdata = (val & keep) | ($urandom & ~keep);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ENABLE:     cfg_shadow.enable          = wdata[0];
			REG_OPEN_LVL:   cfg_shadow.open_level      = wdata[24:0];
			REG_RETRIG_LVL: cfg_shadow.retrigger_level = wdata[24:0];
			REG_CLOSE_LVL:  cfg_shadow.close_level     = wdata[24:0];
			REG_DET_DECAY:  cfg_shadow.detector_decay  = wdata[24:0];
			REG_REL_COEFF:  cfg_shadow.release_coeff   = wdata[24:0];
			REG_HOLD:       cfg_shadow.hold_samples    = wdata[15:0];
			default:        cfg_shadow.confirm_samples = wdata[15:0];
		endcase
		// back-to-back read of the same register
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== (wdata & keep))
			report_mismatch($sformatf("register %0d reads 0x%08h, wrote 0x%08h",
				idx, prdata, wdata & keep));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Pick the register set of one random phase: low extremes, high
	// extremes, bypass, reset defaults, and random settings with short
	// hold and confirm counts so every gate state is visited.
	task automatic configure_phase(input int ph);
		logic [31:0] v [0:7];
		logic [31:0] lvl;
		int          r;
		v[REG_ENABLE]     = 32'($urandom_range(0, 5) != 0);
		lvl               = $urandom_range(0, 1 << 22);
		v[REG_OPEN_LVL]   = lvl;
		v[REG_RETRIG_LVL] = $urandom_range(0, 1 << 23);
		v[REG_CLOSE_LVL]  = $urandom_range(0, lvl);
		v[REG_DET_DECAY]  = ($urandom_range(0, 7) == 0) ?
			$urandom_range(ONE_Q24, 32'h1FF_FFFF) : $urandom_range(0, ONE_Q24);
		v[REG_REL_COEFF]  = ($urandom_range(0, 7) == 0) ?
			$urandom_range(ONE_Q24, 32'h1FF_FFFF) : $urandom_range(0, ONE_Q24);
		v[REG_HOLD]       = $urandom_range(0, 8);
		v[REG_CONFIRM]    = $urandom_range(0, 8);
		case (ph)
			0: begin
				v[REG_ENABLE] = 1;
				for (r = REG_OPEN_LVL; r <= REG_CONFIRM; r++)
					v[r] = 0;
			end
			1: begin
				// levels at full scale can never be crossed
				v[REG_ENABLE]     = 1;
				v[REG_OPEN_LVL]   = ONE_Q24;
				v[REG_RETRIG_LVL] = ONE_Q24;
				v[REG_CLOSE_LVL]  = ONE_Q24;
				v[REG_DET_DECAY]  = 32'h1FF_FFFF;
				v[REG_REL_COEFF]  = 32'h1FF_FFFF;
				v[REG_HOLD]       = 32'hFFFF;
				v[REG_CONFIRM]    = 32'hFFFF;
			end
			2: v[REG_ENABLE] = 0;
			NUM_PHASES - 1: begin
				v[REG_ENABLE]     = 32'(RST_ENABLE);
				v[REG_OPEN_LVL]   = 32'(RST_OPEN_LVL);
				v[REG_RETRIG_LVL] = 32'(RST_RETRIG_LVL);
				v[REG_CLOSE_LVL]  = 32'(RST_CLOSE_LVL);
				v[REG_DET_DECAY]  = 32'(RST_DET_DECAY);
				v[REG_REL_COEFF]  = 32'(RST_REL_COEFF);
				v[REG_HOLD]       = 32'(RST_HOLD);
				v[REG_CONFIRM]    = 32'(RST_CONFIRM);
			end
			default: ;
		endcase
		for (r = REG_ENABLE; r <= REG_CONFIRM; r++)
			access_reg(3'(r), v[r]);
	endtask

	// Result side: check each completed transaction against the oldest
	// booked result, then hold stall for a random number of valid cycles.
	initial begin : result_side
		int        stall_left;
		gate_out_t exp_res;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (gated_q.size() == 0)
					report_mismatch($sformatf("unexpected result 0x%06h state %0d",
						sample_out, gate_state));
				else begin
					exp_res = gated_q.pop_front();
					if (sample_out !== exp_res.sample)
						report_mismatch($sformatf("sample_out 0x%06h, want 0x%06h",
							sample_out, exp_res.sample));
					if (gate_state !== exp_res.state)
						report_mismatch($sformatf("gate_state %0d, want %0d",
							gate_state, exp_res.state));
				end
				stall_left = idle_en ? $urandom_range(0, 6) : 0;
			end else if (out_valid && out_stall && stall_left > 0)
				stall_left--;
			out_stall <= (stall_left > 0);
		end
	end

	// Stimulus: reset, directed table, random phases, drain, verdict
	initial begin : stimulus
		int        i;
		int        ph;
		int        sent;
		int        len;
		burst_t    burst;
		logic [23:0] smp;
		gate_out_t want;

		// mirror the register defaults and the reset state of the gate
		cfg_shadow.enable          = RST_ENABLE;
		cfg_shadow.open_level      = RST_OPEN_LVL;
		cfg_shadow.retrigger_level = RST_RETRIG_LVL;
		cfg_shadow.close_level     = RST_CLOSE_LVL;
		cfg_shadow.detector_decay  = RST_DET_DECAY;
		cfg_shadow.release_coeff   = RST_REL_COEFF;
		cfg_shadow.hold_samples    = RST_HOLD;
		cfg_shadow.confirm_samples = RST_CONFIRM;
		env_lvl     = '0;
		gain_q31    = FLOOR_Q31;
		rel_q31     = FLOOR_Q31;
		hold_cnt    = '0;
		confirm_cnt = '0;
		gate_mode   = MODE_CLOSED;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table; drop valid and drain before each write
		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_tbl[i].kind == ROW_WRITE) begin
				in_valid <= 1'b0;
				settle();
				access_reg(dir_tbl[i].idx, dir_tbl[i].value);
			end else begin
				want.sample = dir_tbl[i].want_out;
				want.state  = dir_tbl[i].want_state;
				send_sample(dir_tbl[i].value[23:0], dir_tbl[i].typed, want);
			end
		end
		in_valid <= 1'b0;

		// random phases of bursts: loud bursts open the gate, quiet and
		// silent ones walk it through hold, closing and closed
		want = '0;
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			configure_phase(ph);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = burst_t'($urandom_range(0, 3));
				len   = $urandom_range(1, 16);
				if (len > PHASE_ITEMS - sent)
					len = PHASE_ITEMS - sent;
				if ($urandom_range(0, 3) == 0)
					idle_en = !idle_en;
				repeat (len) begin
					case (burst)
						BURST_LOUD:   smp = 24'($urandom_range(1 << 21, (1 << 23) - 1));
						BURST_QUIET:  smp = 24'($urandom_range(0, 4095));
						BURST_SILENT: smp = '0;
						default:      smp = 24'($urandom);
					endcase
					if (burst != BURST_NOISE && $urandom_range(0, 1) == 1)
						smp = 24'(0) - smp;
					send_sample(smp, 1'b0, want);
					sent++;
				end
			end
			in_valid <= 1'b0;
		end

		settle();
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[audio_noise_gate_top.f]
rtl/ang_pkg.sv
rtl/ang_regs.sv
rtl/ang_ctrl.sv
rtl/ang_dp.sv
rtl/audio_noise_gate_top.sv
verif/testbench.sv
